[sv/hsb_pkg.sv]
// shared types and constants for the hashed stack bucket table
// no dependencies
package hsb_pkg;

  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;
  localparam int TOTAL_W = 9;

  localparam int MAX_BUCKETS = 16;
  localparam int STACK_DEPTH = 16;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_BUCKET = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

endpackage

[sv/hsb_mod.sv]
// bit-serial remainder unit: |dividend| mod divisor, one quotient bit per cycle
// depends on hsb_pkg
module hsb_mod #(
  parameter int NW = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hsb_pkg::VALUE_W-1:0] dividend,
  input  logic [NW-1:0]               divisor,
  output logic                        done,
  output logic [NW-1:0]               rem
);
  import hsb_pkg::*;

  localparam int CW = $clog2(VALUE_W + 1);

  logic [VALUE_W-1:0] shreg;
  logic [NW-1:0]      dvs;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic [NW:0]        trial;
  logic [NW:0]        trial_sub;

  assign trial     = {rem, shreg[VALUE_W-1]};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend[VALUE_W-1] ? (~dividend + 1'b1) : dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= trial_sub[NW-1:0];
      end else begin
        rem <= trial[NW-1:0];
      end
    end
  end

endmodule

[sv/hsb_store.sv]
// value store for all bucket stacks, one write and one registered read port
// depends on hsb_pkg
module hsb_store #(
  parameter int AW = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [hsb_pkg::VALUE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [hsb_pkg::VALUE_W-1:0] rdata
);
  import hsb_pkg::*;

  logic [VALUE_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/hashed_stack_buckets_with_max.sv]
// top level of the hashed stack bucket table with largest-bucket report
// depends on hsb_pkg, hsb_mod, hsb_store
//
//   channel | signals                                                    | dir
//   in      | in_valid in_ready kind value bucket                        | in
//   out     | out_valid out_ready status total_count max_valid max_bucket | out
//   cfg     | cfg_valid cfg_ready cfg_data                               | in
//
// add: the remainder unit picks the bucket, then the update state, then a scan of
// the per-bucket maxima over the buckets in use, then the result state
// remove: the update state, then a rescan of the popped bucket through the store
// read port (left at once when it empties), then the scan of the maxima and the result state
// reset clears fills and total and sets config to 10; store contents and bucket maxima are not cleared
// a result waiting on out_ready holds the block in its final state only
module hashed_stack_buckets_with_max (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [0:0]                  kind,
  input  logic signed [31:0]          value,
  input  logic [3:0]                  bucket,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hsb_pkg::status_t            status,
  output logic [8:0]                  total_count,
  output logic                        max_valid,
  output logic [3:0]                  max_bucket,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [4:0]                  cfg_data
);
  import hsb_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RS   = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]               state;
  logic [CFG_W-1:0]         cfg;
  logic [NW-1:0]            n_use;
  logic [NW-1:0]            n_lat;
  logic                     op_kind;
  logic signed [VALUE_W-1:0] op_value;
  logic [3:0]               op_bucket;
  status_t                  op_status;
  logic [BW-1:0]            cur;
  logic [FW-1:0]            fill [MAX_BUCKETS];
  logic signed [VALUE_W-1:0] bmax [MAX_BUCKETS];
  logic [TOTAL_W-1:0]       total;
  logic [FW-1:0]            k;
  logic                     pend;
  logic                     seen;
  logic signed [VALUE_W-1:0] best;
  logic [BW-1:0]            best_bucket;
  logic [NW-1:0]            scan_i;
  logic [FW-1:0]            fill_cur;
  logic [FW-1:0]            fill_scan;
  logic                     div_start;
  logic                     div_done;
  logic [NW-1:0]            div_rem;
  logic                     st_we;
  logic                     st_re;
  logic [BW+AW-1:0]         st_waddr;
  logic [BW+AW-1:0]         st_raddr;
  logic [VALUE_W-1:0]       st_rdata;
  logic [8:0]               bb9;

  always_comb begin
    if (cfg == '0) begin
      n_use = NW'(1);
    end else if (9'(cfg) > 9'(MAX_BUCKETS)) begin
      n_use = NW'(MAX_BUCKETS);
    end else begin
      n_use = NW'(cfg);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign fill_cur  = fill[cur];
  assign fill_scan = fill[scan_i[BW-1:0]];
  assign div_start = (state == S_IDLE) && in_valid && !kind[0];
  assign st_we     = (state == S_CHK) && !op_kind && (fill_cur != FW'(STACK_DEPTH));
  assign st_waddr  = {cur, fill_cur[AW-1:0]};
  assign st_re     = (state == S_RS) && (k < fill_cur);
  assign st_raddr  = {cur, k[AW-1:0]};
  assign bb9       = 9'(best_bucket);

  hsb_mod #(.NW(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (value),
    .divisor  (n_use),
    .done     (div_done),
    .rem      (div_rem)
  );

  hsb_store #(.AW(BW + AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (op_value),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      total     <= '0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind   <= kind[0];
            op_value  <= value;
            op_bucket <= bucket;
            op_status <= ST_OK;
            n_lat     <= n_use;
            if (kind[0]) begin
              cur   <= BW'(bucket);
              state <= S_CHK;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cur   <= div_rem[BW-1:0];
            state <= S_CHK;
          end
        end
        S_CHK: begin
          scan_i <= '0;
          seen   <= 1'b0;
          if (!op_kind) begin
            state <= S_SCAN;
            if (fill_cur == FW'(STACK_DEPTH)) begin
              op_status <= ST_FULL;
            end else begin
              fill[cur] <= fill_cur + 1'b1;
              total     <= total + 1'b1;
              if (fill_cur == '0 || op_value > bmax[cur]) begin
                bmax[cur] <= op_value;
              end
            end
          end else if (9'(op_bucket) >= 9'(n_lat)) begin
            op_status <= ST_NO_BUCKET;
            state     <= S_SCAN;
          end else if (fill_cur == '0) begin
            op_status <= ST_EMPTY;
            state     <= S_SCAN;
          end else begin
            fill[cur] <= fill_cur - 1'b1;
            total     <= total - 1'b1;
            k         <= '0;
            pend      <= 1'b0;
            state     <= S_RS;
          end
        end
        S_RS: begin
          if (k < fill_cur) begin
            k <= k + 1'b1;
          end
          pend <= (k < fill_cur);
          if (pend && (!seen || $signed(st_rdata) > best)) begin
            best <= $signed(st_rdata);
          end
          if (pend) begin
            seen <= 1'b1;
          end
          if (k == fill_cur && !pend) begin
            if (fill_cur != '0) begin
              bmax[cur] <= best;
            end
            seen  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_i < n_lat) begin
            if (fill_scan != '0 && (!seen || bmax[scan_i[BW-1:0]] > best)) begin
              best        <= bmax[scan_i[BW-1:0]];
              best_bucket <= scan_i[BW-1:0];
              seen        <= 1'b1;
            end
            scan_i <= scan_i + 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status      <= op_status;
            total_count <= total;
            max_valid   <= seen;
            max_bucket  <= seen ? bb9[3:0] : 4'd0;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/hsb_check.sv]
// port-level checks for the hashed stack bucket table, bound to the top level
// depends on hsb_pkg and hashed_stack_buckets_with_max
module hsb_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hsb_pkg::status_t    status,
  input logic [8:0]          total_count,
  input logic                max_valid,
  input logic [3:0]          max_bucket
);
  import hsb_pkg::*;

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_count) && $stable(status))
    else $error("result changed while stalled");

  a_empty_bucket: assert property (@(posedge clk) disable iff (rst)
    out_valid && !max_valid |-> max_bucket == 4'd0)
    else $error("max bucket nonzero on empty table");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_count == 9'd0 |-> !max_valid)
    else $error("max flagged with zero total");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hashed_stack_buckets_with_max hsb_check u_hsb_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .total_count (total_count),
  .max_valid   (max_valid),
  .max_bucket  (max_bucket)
);
